### hdl/rfb_pkg.sv
`default_nettype none
package rfb_pkg;

  localparam int DEF_MAX_SIZE_LOG2    = 12;
  localparam int DEF_WEIGHT_FRAC_BITS = 16;

  localparam int COORD_W  = 13;
  localparam int GRAY_W   = 8;
  localparam int SIZE_W   = 4;
  localparam int EDGE_W   = 8;
  localparam int E2_W     = 2 * EDGE_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_LOG2       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_SMOOTHNESS = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SQUARE_FALLOFF  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_OUTPUT   = 8'd3;

  localparam logic [SIZE_W-1:0] RST_SIZE_LOG2       = 4'd9;
  localparam logic [EDGE_W-1:0] RST_EDGE_SMOOTHNESS = 8'd1;

  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

endpackage
`default_nettype wire

### hdl/radial_falloff_brush_pixel.sv
`default_nettype none
// Radial falloff brush: one pixel word in, one faded gray word out, fully pipelined.
// A pixel may enter every clock while the output is not stalled; the pipe runs through
// distance math, restoring division (one quotient bit per stage), square root (one root
// bit per stage) and then weighting and blend. A stalled output holds the whole pipe.
// Registers are written through the cfg port, which is always ready; the user must
// write them only while idle, as the block itself does not enforce it.
module radial_falloff_brush_pixel #(
  parameter int MAX_SIZE_LOG2    = rfb_pkg::DEF_MAX_SIZE_LOG2,
  parameter int WEIGHT_FRAC_BITS = rfb_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [12:0] pix_col, [25:13] pix_row, [33:26] gray_level
  input  logic [rfb_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] brush_value
  output logic [rfb_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rfb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rfb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rfb_pkg::*;

  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int CW  = (MAX_SIZE_LOG2 + 1 > COORD_W) ? MAX_SIZE_LOG2 + 1 : COORD_W;
  localparam int NW  = 2 * CW + 1 + 2 * F;
  localparam int QW  = 2 * F;
  localparam int SW  = GRAY_W + 1;

  logic [SIZE_W-1:0] size_log2;
  logic [EDGE_W-1:0] edge_smoothness;
  logic              square_falloff;
  logic              invert_output;
  logic [E2_W-1:0]   e2;

  logic              en;
  logic              d_valid, d_sat;
  logic [NW-1:0]     d_num;
  logic [GRAY_W-1:0] d_gray;
  logic              q_valid;
  logic [QW-1:0]     q_quo;
  logic [SW-1:0]     q_side;
  logic              r_valid;
  logic [F-1:0]      r_root;
  logic [SW-1:0]     r_side;
  logic [GRAY_W-1:0] brush_value;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign m_tdata   = brush_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2       <= RST_SIZE_LOG2;
      edge_smoothness <= RST_EDGE_SMOOTHNESS;
      square_falloff  <= 1'b0;
      invert_output   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SIZE_LOG2:       size_log2       <= cfg_data[SIZE_W-1:0];
        CFG_EDGE_SMOOTHNESS: edge_smoothness <= cfg_data[EDGE_W-1:0];
        CFG_SQUARE_FALLOFF:  square_falloff  <= cfg_data[0];
        CFG_INVERT_OUTPUT:   invert_output   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // divisor for the whole pipe; config must only move while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    e2 <= edge_smoothness * edge_smoothness;
  end

  rfb_dist #(
    .MAX_SIZE_LOG2(MAX_SIZE_LOG2), .WEIGHT_FRAC_BITS(F), .CW(CW), .NW(NW)
  ) u_dist (
    .clk, .rst, .en,
    .in_valid(s_tvalid && s_tready),
    .pix_col(s_tdata[12:0]),
    .pix_row(s_tdata[25:13]),
    .gray_level(s_tdata[33:26]),
    .size_log2, .edge_smoothness,
    .out_valid(d_valid), .sat(d_sat), .num(d_num), .gray(d_gray)
  );

  rfb_div #(.NW(NW), .DW(E2_W), .QW(QW), .SW(SW)) u_div (
    .clk, .rst, .en,
    .in_valid(d_valid), .num(d_num), .den(e2), .side_in({d_sat, d_gray}),
    .out_valid(q_valid), .quo(q_quo), .side_out(q_side)
  );

  rfb_sqrt #(.QW(QW), .SW(SW)) u_sqrt (
    .clk, .rst, .en,
    .in_valid(q_valid), .rad(q_quo), .side_in(q_side),
    .out_valid(r_valid), .root(r_root), .side_out(r_side)
  );

  rfb_blend #(.WEIGHT_FRAC_BITS(F)) u_blend (
    .clk, .rst, .en,
    .in_valid(r_valid), .root(r_root),
    .sat(r_side[SW-1]), .gray(r_side[GRAY_W-1:0]),
    .square_falloff, .invert_output,
    .out_valid(m_tvalid), .brush_value
  );

endmodule
`default_nettype wire

### hdl/rfb_dist.sv
`default_nettype none
module rfb_dist #(
  parameter int MAX_SIZE_LOG2    = 12,
  parameter int WEIGHT_FRAC_BITS = 16,
  parameter int CW               = 13,
  parameter int NW               = 59
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [rfb_pkg::COORD_W-1:0]  pix_col,
  input  logic [rfb_pkg::COORD_W-1:0]  pix_row,
  input  logic [rfb_pkg::GRAY_W-1:0]   gray_level,
  input  logic [rfb_pkg::SIZE_W-1:0]   size_log2,
  input  logic [rfb_pkg::EDGE_W-1:0]   edge_smoothness,
  output logic                         out_valid,
  output logic                         sat,
  output logic [NW-1:0]                num,
  output logic [rfb_pkg::GRAY_W-1:0]   gray
);
  import rfb_pkg::*;

  localparam int D2W = 2 * CW + 1;
  localparam int LW  = E2_W + 2 * MAX_SIZE_LOG2;
  localparam int CMW = LW + D2W;
  localparam int SF  = 2 * WEIGHT_FRAC_BITS;
  localparam int SHW = 8;

  logic [4:0]    kc;
  logic [5:0]    sk;
  logic [CW-1:0] half, colx, rowx;

  logic              v1, v2;
  logic [CW-1:0]     dx, dy;
  logic [GRAY_W-1:0] g1, g2;
  logic [2*CW-1:0]   dx2, dy2;
  logic [E2_W-1:0]   e2;

  logic [D2W-1:0] dist2;
  logic [LW-1:0]  lim;
  logic [NW-1:0]  num_next;

  always_comb begin
    if (size_log2 == '0) begin
      kc = 5'd1;
    end else if (5'(size_log2) > 5'(MAX_SIZE_LOG2)) begin
      kc = 5'(MAX_SIZE_LOG2);
    end else begin
      kc = 5'(size_log2);
    end
    sk   = {kc, 1'b0} - 6'd1;
    half = CW'(1) << (kc - 5'd1);
    colx = CW'(pix_col);
    rowx = CW'(pix_row);
  end

  always_comb begin
    dist2 = D2W'(dx2) + D2W'(dy2);
    lim   = LW'(e2) << sk;
    if (SHW'(SF) >= SHW'(sk)) begin
      num_next = NW'(dist2) << (SHW'(SF) - SHW'(sk));
    end else begin
      num_next = NW'(dist2) >> (SHW'(sk) - SHW'(SF));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx   <= (colx >= half) ? colx - half : half - colx;
      dy   <= (rowx >= half) ? rowx - half : half - rowx;
      g1   <= gray_level;
      dx2  <= dx * dx;
      dy2  <= dy * dy;
      e2   <= edge_smoothness * edge_smoothness;
      g2   <= g1;
      sat  <= (e2 == '0) || (CMW'(dist2) >= CMW'(lim));
      num  <= num_next;
      gray <= g2;
    end
  end

endmodule
`default_nettype wire

### hdl/rfb_div.sv
`default_nettype none
module rfb_div #(
  parameter int NW = 59,
  parameter int DW = 16,
  parameter int QW = 32,
  parameter int SW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  // one quotient bit per stage, msb first
  logic [NW-1:0] rem [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [SW-1:0] sd  [QW+1];
  logic          vl  [QW+1];

  assign rem[0] = num;
  assign q[0]   = '0;
  assign sd[0]  = side_in;
  assign vl[0]  = in_valid;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic [NW-1:0] dsh;
    assign dsh = NW'(den) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[j+1] <= 1'b0;
      end else if (en) begin
        vl[j+1] <= vl[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1] <= sd[j];
        if (rem[j] >= dsh) begin
          rem[j+1] <= rem[j] - dsh;
          q[j+1]   <= q[j] | (QW'(1) << B);
        end else begin
          rem[j+1] <= rem[j];
          q[j+1]   <= q[j];
        end
      end
    end
  end

  assign out_valid = vl[QW];
  assign quo       = q[QW];
  assign side_out  = sd[QW];

endmodule
`default_nettype wire

### hdl/rfb_sqrt.sv
`default_nettype none
module rfb_sqrt #(
  parameter int QW = 32,
  parameter int SW = 9
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [QW-1:0]   rad,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [QW/2-1:0] root,
  output logic [SW-1:0]   side_out
);

  localparam int RW = QW / 2;
  localparam int RM = QW + 2;

  // rem holds rad minus root squared; one root bit per stage
  logic [RM-1:0] rem [RW+1];
  logic [RW-1:0] rt  [RW+1];
  logic [SW-1:0] sd  [RW+1];
  logic          vl  [RW+1];

  assign rem[0] = RM'(rad);
  assign rt[0]  = '0;
  assign sd[0]  = side_in;
  assign vl[0]  = in_valid;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int I = RW - 1 - j;
    logic [RM-1:0] tst;
    assign tst = (RM'(rt[j]) << (I + 1)) + (RM'(1) << (2 * I));

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[j+1] <= 1'b0;
      end else if (en) begin
        vl[j+1] <= vl[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1] <= sd[j];
        if (rem[j] >= tst) begin
          rem[j+1] <= rem[j] - tst;
          rt[j+1]  <= rt[j] | (RW'(1) << I);
        end else begin
          rem[j+1] <= rem[j];
          rt[j+1]  <= rt[j];
        end
      end
    end
  end

  assign out_valid = vl[RW];
  assign root      = rt[RW];
  assign side_out  = sd[RW];

endmodule
`default_nettype wire

### hdl/rfb_blend.sv
`default_nettype none
module rfb_blend #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [WEIGHT_FRAC_BITS-1:0] root,
  input  logic                        sat,
  input  logic [rfb_pkg::GRAY_W-1:0]  gray,
  input  logic                        square_falloff,
  input  logic                        invert_output,
  output logic                        out_valid,
  output logic [rfb_pkg::GRAY_W-1:0]  brush_value
);
  import rfb_pkg::*;

  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int WW = F + 1;
  localparam int PW = GRAY_W + WW;
  localparam logic [WW-1:0] ONE = WW'(1) << F;

  logic              v1, v2, v3;
  logic [WW-1:0]     w1, w2;
  logic [GRAY_W-1:0] g1, g2;
  logic [PW-1:0]     prod;
  logic [2*WW-1:0]   wsq;
  logic [GRAY_W-1:0] fade;

  assign wsq  = w1 * w1;
  assign fade = GRAY_W'(prod >> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1   <= sat ? ONE : WW'(root);
      g1   <= gray;
      w2   <= square_falloff ? WW'(wsq >> F) : w1;
      g2   <= g1;
      prod <= g2 * (ONE - w2);
      brush_value <= invert_output ? GRAY_MAX - fade : fade;
    end
  end

  a_w1_range: assert property (@(posedge clk) disable iff (rst) v1 |-> w1 <= ONE)
    else $error("linear weight above one");
  a_w2_range: assert property (@(posedge clk) disable iff (rst) v2 |-> w2 <= ONE)
    else $error("shaped weight above one");
  a_fade_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (prod >> F) <= PW'(GRAY_MAX))
    else $error("faded value out of range");

endmodule
`default_nettype wire

### verif/radial_falloff_brush_pixel_tb.sv
`timescale 1ns / 1ps
import rfb_pkg::*;

class brush_scoreboard;
  logic [3:0] size_log2;
  logic [7:0] edge_smooth;
  logic       square_falloff;
  logic       invert_output;
  logic [7:0] pending[$];
  int         mismatches;

  function new();
    size_log2 = RST_SIZE_LOG2;
    edge_smooth = RST_EDGE_SMOOTHNESS;
    square_falloff = 1'b0;
    invert_output = 1'b0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [7:0] val);
    case (idx)
      CFG_SIZE_LOG2:       size_log2 = val[3:0];
      CFG_EDGE_SMOOTHNESS: edge_smooth = val;
      CFG_SQUARE_FALLOFF:  square_falloff = val[0];
      CFG_INVERT_OUTPUT:   invert_output = val[0];
      default: ;
    endcase
  endfunction

  function longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function logic [7:0] fade(logic [12:0] col, logic [12:0] row, logic [7:0] gray);
    int unsigned k, sk;
    longint unsigned half, dx, dy, d2, one, w, e2, lim, q, bl;
    k = size_log2;
    if (k < 1) k = 1;
    if (k > DEF_MAX_SIZE_LOG2) k = DEF_MAX_SIZE_LOG2;
    half = 64'd1 << (k - 1);
    dx = (col >= half) ? col - half : half - col;
    dy = (row >= half) ? row - half : half - row;
    d2 = dx * dx + dy * dy;
    one = 64'd1 << DEF_WEIGHT_FRAC_BITS;
    e2 = edge_smooth * edge_smooth;
    sk = 2 * k - 1;
    if (e2 == 0) begin
      w = one;
    end else begin
      lim = e2 << sk;
      if (d2 >= lim) begin
        w = one;
      end else begin
        q = (d2 << (2 * DEF_WEIGHT_FRAC_BITS - sk)) / e2;
        w = isqrt(q);
        if (w > one) w = one;
      end
    end
    if (square_falloff) w = (w * w) >> DEF_WEIGHT_FRAC_BITS;
    bl = (gray * (one - w)) >> DEF_WEIGHT_FRAC_BITS;
    if (bl > 255) bl = 255;
    if (invert_output) bl = 255 - bl;
    return bl[7:0];
  endfunction

  function void note_pixel(logic [39:0] d);
    pending.push_back(fade(d[12:0], d[25:13], d[33:26]));
  endfunction

  function void check_brush(logic [7:0] got);
    logic [7:0] exp_v;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word %0d", got);
      return;
    end
    exp_v = pending.pop_front();
    if (exp_v !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("brush_value exp %0d got %0d", exp_v, got);
    end
  endfunction
endclass

module radial_falloff_brush_pixel_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  brush_scoreboard sb = new();
  bit hold_off = 1'b0;
  bit sending = 1'b1;
  int cycles = 0;

  radial_falloff_brush_pixel uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("radial_falloff_brush_pixel verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_brush(m_tdata);
    if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
  end

  // receiver: random stalls, with one long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (!sending) n = 0;
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // tvalid stays high after a word so back-to-back words need no gap
  task automatic send_pixel(logic [12:0] col, logic [12:0] row, logic [7:0] gray, bit burst);
    int n;
    n = burst ? 0 : $urandom_range(0, 13);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, gray, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic set_all(logic [3:0] k, logic [7:0] e, bit sq, bit inv);
    drain();
    write_cfg(CFG_SIZE_LOG2, 8'(k));
    write_cfg(CFG_EDGE_SMOOTHNESS, e);
    write_cfg(CFG_SQUARE_FALLOFF, 8'(sq));
    write_cfg(CFG_INVERT_OUTPUT, 8'(inv));
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_pixel(bit burst);
    int unsigned side;
    logic [12:0] c, r;
    side = (1 << sb.size_log2) + 1;
    if (sb.size_log2 > 12 || sb.size_log2 == 0) side = 4097;
    if ($urandom_range(0, 9) == 0) begin
      c = 13'($urandom);
      r = 13'($urandom);
    end else begin
      c = 13'($urandom_range(0, side - 1));
      r = 13'($urandom_range(0, side - 1));
    end
    send_pixel(c, r, 8'($urandom), burst);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: defaults, centre, corners, beyond image, extreme grays
    send_pixel(13'd256, 13'd256, 8'd255, 0);
    send_pixel(13'd0, 13'd0, 8'd255, 0);
    send_pixel(13'd512, 13'd512, 8'd200, 0);
    send_pixel(13'h1FFF, 13'h1FFF, 8'd255, 0);
    send_pixel(13'd300, 13'd200, 8'd0, 0);
    set_all(4'd12, 8'd255, 1'b1, 1'b1);
    send_pixel(13'd4096, 13'd0, 8'd255, 0);
    send_pixel(13'd2048, 13'd2048, 8'd255, 0);
    send_pixel(13'd4096, 13'd4096, 8'd128, 0);
    send_pixel(13'h1FFF, 13'd0, 8'd255, 0);
    set_all(4'd1, 8'd0, 1'b0, 1'b1);   // zero smoothness
    send_pixel(13'd1, 13'd1, 8'd255, 0);
    send_pixel(13'd2, 13'd0, 8'd77, 0);
    set_all(4'd0, 8'd1, 1'b1, 1'b0);   // size below range
    send_pixel(13'd1, 13'd0, 8'd255, 0);
    send_pixel(13'd0, 13'd2, 8'd255, 0);
    set_all(4'd15, 8'd3, 1'b0, 1'b0);  // size above range
    send_pixel(13'd2048, 13'd100, 8'd255, 0);
    send_pixel(13'd5000, 13'd8000, 8'd255, 0);
    // random phases across settings
    for (int p = 0; p < 10; p++) begin
      set_all(4'($urandom_range(1, 12)), (p == 0) ? 8'd1 : (p == 1) ? 8'd255
              : 8'($urandom_range(1, 255)), 1'($urandom), 1'($urandom));
      if (p == 4) hold_off = 1'b1;
      for (int i = 0; i < 50; i++) rand_pixel(p == 4 || $urandom_range(0, 3) == 0);
    end
    sending = 1'b0;
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("radial_falloff_brush_pixel verification clean");
    end else begin
      $display("radial_falloff_brush_pixel verification failed");
    end
    $finish;
  end
endmodule

### files.f
hdl/rfb_pkg.sv
hdl/rfb_dist.sv
hdl/rfb_div.sv
hdl/rfb_sqrt.sv
hdl/rfb_blend.sv
hdl/radial_falloff_brush_pixel.sv
verif/radial_falloff_brush_pixel_tb.sv
